/* rtl/dsh_pkg.sv */
// shared types, widths, codes and tables for the horn slope block
package dsh_pkg;

    // raster geometry and sample format
    localparam int MAX_COLUMNS  = 4096;
    localparam int COL_W        = $clog2(MAX_COLUMNS);
    localparam int SAMPLE_W     = 32;
    localparam int LEN_W        = 13;
    localparam int CELL_W       = 24;
    localparam int CFG_IDX_W    = 3;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODATA_VALUE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_MODE   = 3'd3;

    // reset values of the registers
    localparam logic [LEN_W-1:0]    RST_ROW_LENGTH   = 13'd4096;
    localparam logic [SAMPLE_W-1:0] RST_NODATA_VALUE = 32'hFFD8_F000;
    localparam logic [CELL_W-1:0]   RST_CELL_SIZE    = 24'd256;

    // gradient and square root datapath widths
    localparam int GRAD_W  = 35;
    localparam int MAG_W   = 34;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUM_W   = SQ_W + 1;
    localparam int RAD_W   = 102;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 4;
    localparam int DVS_W   = CELL_W + 3;
    localparam int DREM_W  = DVS_W + 1;
    localparam int TAN_W   = 41;
    localparam int PCT_W   = 48;
    localparam int CX_W    = 64;
    localparam int ANG_W   = 25;
    localparam int CNT_W   = 6;

    // iteration counts of the shared sequential units
    localparam int ROOT_STEPS   = ROOT_W;
    localparam int DIV_STEPS    = ROOT_W;
    localparam int CORDIC_STEPS = 23;

    localparam logic [TAN_W-1:0] TAN_CAP   = 41'h100_0000_0000;
    localparam logic [ANG_W-1:0] DEG90_Q16 = 25'd5898240;
    localparam logic [SAMPLE_W-1:0] PCT_MAX = 32'h7FFF_FFFF;

    // arctangent of 2^-i in Q.16 degrees
    function automatic logic [ANG_W-1:0] atan_q16(input logic [4:0] idx);
        logic [ANG_W-1:0] v;
        case (idx)
            5'd0:    v = 25'd2949120;
            5'd1:    v = 25'd1740967;
            5'd2:    v = 25'd919879;
            5'd3:    v = 25'd466945;
            5'd4:    v = 25'd234379;
            5'd5:    v = 25'd117304;
            5'd6:    v = 25'd58666;
            5'd7:    v = 25'd29335;
            5'd8:    v = 25'd14668;
            5'd9:    v = 25'd7334;
            5'd10:   v = 25'd3667;
            5'd11:   v = 25'd1833;
            5'd12:   v = 25'd917;
            5'd13:   v = 25'd458;
            5'd14:   v = 25'd229;
            5'd15:   v = 25'd115;
            5'd16:   v = 25'd57;
            5'd17:   v = 25'd29;
            5'd18:   v = 25'd14;
            5'd19:   v = 25'd7;
            5'd20:   v = 25'd4;
            5'd21:   v = 25'd2;
            5'd22:   v = 25'd1;
            default: v = 25'd0;
        endcase
        return v;
    endfunction

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_DECIDE,
        S_SQX,
        S_SQY,
        S_SUM,
        S_ROOT,
        S_DIVI,
        S_DIV,
        S_CAP,
        S_CORD,
        S_FIN,
        S_EMIT1,
        S_EMIT2
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic ram_wr;
        logic latch_grad;
        logic sq_x;
        logic sq_y;
        logic init_root;
        logic step_root;
        logic init_div;
        logic step_div;
        logic cap;
        logic step_cord;
        logic fin;
        logic load_out;
        logic out_nod;
        logic out_last;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic act;
        logic col0;
        logic cmp;
        logic sec;
        logic win_nod;
        logic mode;
        logic tan_zero;
        logic root_done;
        logic div_done;
        logic cord_done;
        logic out_free;
    } t_status;

endpackage

/* rtl/dem_slope_3x3_horn_core.sv */
// top level of the horn 3x3 slope block
//
// Elevation samples enter in row-major order on the i_valid / o_ready
// channel, one item at a time. Results leave on o_valid / i_ready with
// slope value, nodata flag and a last-of-run flag on the final result of
// each input item. Configuration writes (row length, nodata code, cell
// size, slope mode) use i_cfg_valid / o_cfg_ready and are always taken.
// Each item reads both line buffers, shifts the window and plans its
// results. Items in the first two rows, and the second column, release
// nothing. Border and nodata cells skip the arithmetic units. A computed
// cell runs the shared sequential units: 51 square root steps, 51 divide
// steps and, for degrees with a nonzero tangent, 23 cordic steps; these
// loops set the rate. A row-end item delivers one more result after the
// first, a nodata border result.
// The next item is taken once the last result sits in the output
// register, so a stalled receiver holds at most that one result before
// the block stops. Reset clears counters, state and the output valid and
// loads the register defaults; line buffer contents stay undefined.
module dem_slope_3x3_horn_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dsh_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dsh_pkg::SAMPLE_W-1:0]  i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [dsh_pkg::SAMPLE_W-1:0] i_elevation,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [dsh_pkg::SAMPLE_W-1:0] o_slope_value,
    output logic                          o_is_nodata,
    output logic                          o_last_of_run
);
    import dsh_pkg::*;

    t_cmd    cmd;
    t_status st;

    assign o_cfg_ready = 1'b1;

    // sequencer
    dsh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_st    (st),
        .o_ready (o_ready),
        .o_cmd   (cmd)
    );

    // storage and arithmetic
    dsh_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_elevation   (i_elevation),
        .i_ready       (i_ready),
        .i_cmd         (cmd),
        .o_st          (st),
        .o_valid       (o_valid),
        .o_slope_value (o_slope_value),
        .o_is_nodata   (o_is_nodata),
        .o_last_of_run (o_last_of_run)
    );
endmodule

/* rtl/dsh_ram.sv */
// generic single write port ram with registered read
module dsh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/dsh_dp.sv */
// datapath: registers, line buffers, window, gradient, root, divide, cordic
module dsh_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [dsh_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dsh_pkg::SAMPLE_W-1:0]   i_cfg_data,
    input  logic signed [dsh_pkg::SAMPLE_W-1:0] i_elevation,
    input  logic                           i_ready,
    input  dsh_pkg::t_cmd                  i_cmd,
    output dsh_pkg::t_status               o_st,
    output logic                           o_valid,
    output logic signed [dsh_pkg::SAMPLE_W-1:0] o_slope_value,
    output logic                           o_is_nodata,
    output logic                           o_last_of_run
);
    import dsh_pkg::*;

    logic [LEN_W-1:0]    r_row_length;
    logic [SAMPLE_W-1:0] r_nodata;
    logic [CELL_W-1:0]   r_cell;
    logic                r_mode;

    logic [COL_W-1:0]    r_col;
    logic [1:0]          r_rows;
    logic signed [SAMPLE_W-1:0] r_elev;
    logic signed [SAMPLE_W-1:0] r_win [9];
    logic [SAMPLE_W-1:0] top_rd;
    logic [SAMPLE_W-1:0] mid_rd;

    logic r_act, r_col0, r_cmp, r_sec;

    logic [MAG_W-1:0]  r_mx, r_my;
    logic [SQ_W-1:0]   r_sq, r_sq2;
    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [ROOT_W-1:0] r_dvd;
    logic [DREM_W-1:0] r_drem;
    logic [CNT_W-1:0]  r_cnt;
    logic signed [CX_W-1:0]  r_x, r_y;
    logic signed [ANG_W-1:0] r_z;
    logic [SAMPLE_W-1:0] r_result;

    logic                r_ov;
    logic [SAMPLE_W-1:0] r_out_val;
    logic                r_out_nod;
    logic                r_out_last;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= RST_ROW_LENGTH;
            r_nodata     <= RST_NODATA_VALUE;
            r_cell       <= RST_CELL_SIZE;
            r_mode       <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROW_LENGTH:   r_row_length <= i_cfg_data[LEN_W-1:0];
                CFG_NODATA_VALUE: r_nodata     <= i_cfg_data;
                CFG_CELL_SIZE:    r_cell       <= i_cfg_data[CELL_W-1:0];
                CFG_SLOPE_MODE:   r_mode       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // line buffers, both indexed by the column
    dsh_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_COLUMNS)) u_upper (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_wr),
        .i_waddr (r_col),
        .i_wdata (mid_rd),
        .i_re    (i_cmd.accept),
        .i_raddr (r_col),
        .o_rdata (top_rd)
    );

    dsh_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_COLUMNS)) u_middle (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_wr),
        .i_waddr (r_col),
        .i_wdata (r_elev),
        .i_re    (i_cmd.accept),
        .i_raddr (r_col),
        .o_rdata (mid_rd)
    );

    // effective row length and last column test
    logic [LEN_W-1:0] len_c;
    logic             is_last;
    always_comb begin
        if (r_row_length < LEN_W'(3)) begin
            len_c = LEN_W'(3);
        end else if (r_row_length > LEN_W'(MAX_COLUMNS)) begin
            len_c = LEN_W'(MAX_COLUMNS);
        end else begin
            len_c = r_row_length;
        end
        is_last = {1'b0, r_col} >= (len_c - LEN_W'(1));
    end

    // column and row counters, result plan of this item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_rows <= '0;
            r_act  <= 1'b0;
            r_col0 <= 1'b0;
            r_cmp  <= 1'b0;
            r_sec  <= 1'b0;
        end else if (i_cmd.ram_wr) begin
            r_act  <= (r_rows == 2'd2);
            r_col0 <= (r_col == '0);
            r_cmp  <= (r_col >= COL_W'(2));
            r_sec  <= is_last && (r_col != '0);
            if (is_last) begin
                r_col <= '0;
                if (r_rows != 2'd2) begin
                    r_rows <= r_rows + 2'd1;
                end
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // sample latch and 3x3 window shift
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_elev <= i_elevation;
        end
        if (i_cmd.ram_wr) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= top_rd;
            r_win[3] <= r_win[4];
            r_win[4] <= r_win[5];
            r_win[5] <= mid_rd;
            r_win[6] <= r_win[7];
            r_win[7] <= r_win[8];
            r_win[8] <= r_elev;
        end
    end

    // nodata anywhere in the window
    logic win_nod;
    always_comb begin
        win_nod = 1'b0;
        for (int k = 0; k < 9; k++) begin
            if (r_win[k] == r_nodata) begin
                win_nod = 1'b1;
            end
        end
    end

    // horn gradients
    logic signed [GRAD_W-1:0] gx, gy;
    logic [GRAD_W-1:0]        ax, ay;
    always_comb begin
        gx = (GRAD_W'(r_win[2]) - GRAD_W'(r_win[0]))
           + ((GRAD_W'(r_win[5]) - GRAD_W'(r_win[3])) <<< 1)
           + (GRAD_W'(r_win[8]) - GRAD_W'(r_win[6]));
        gy = (GRAD_W'(r_win[0]) - GRAD_W'(r_win[6]))
           + ((GRAD_W'(r_win[1]) - GRAD_W'(r_win[7])) <<< 1)
           + (GRAD_W'(r_win[2]) - GRAD_W'(r_win[8]));
        ax = gx[GRAD_W-1] ? -gx : gx;
        ay = gy[GRAD_W-1] ? -gy : gy;
    end

    // one square root digit per step
    logic [REM_W-1:0] rem_sh, trial;
    logic             root_ge;
    always_comb begin
        rem_sh  = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
        trial   = {2'b00, r_root, 2'b01};
        root_ge = rem_sh >= trial;
    end

    // one quotient bit per step
    logic [CELL_W-1:0] cell_c;
    logic [DVS_W-1:0]  dvs;
    logic [DREM_W-1:0] drem_sh;
    logic              div_ge;
    always_comb begin
        cell_c  = (r_cell == '0) ? CELL_W'(1) : r_cell;
        dvs     = {cell_c, 3'b000};
        drem_sh = {r_drem[DREM_W-2:0], r_dvd[ROOT_W-1]};
        div_ge  = drem_sh >= {1'b0, dvs};
    end

    // tangent cap and percent
    logic [TAN_W-1:0] tan_c;
    logic [PCT_W-1:0] pct_full;
    logic [SAMPLE_W-1:0] pct;
    always_comb begin
        tan_c = (r_dvd > ROOT_W'(TAN_CAP)) ? TAN_CAP : r_dvd[TAN_W-1:0];
        pct_full = {7'd0, tan_c} * PCT_W'(100) + PCT_W'(128);
        pct = (pct_full[PCT_W-1:8] > (PCT_W-8)'(PCT_MAX)) ? PCT_MAX
                                                           : pct_full[8 +: SAMPLE_W];
    end

    // cordic step and final angle rounding
    logic signed [CX_W-1:0]  dx, dy;
    logic signed [ANG_W-1:0] ang;
    logic [ANG_W-1:0]        z_c, z_rnd;
    always_comb begin
        dx  = r_y >>> r_cnt;
        dy  = r_x >>> r_cnt;
        ang = atan_q16(r_cnt[4:0]);
        if (r_z < 0) begin
            z_c = '0;
        end else if (r_z > $signed(DEG90_Q16)) begin
            z_c = DEG90_Q16;
        end else begin
            z_c = r_z;
        end
        z_rnd = z_c + ANG_W'(128);
    end

    // arithmetic sequence registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_grad) begin
            r_mx <= ax[MAG_W-1:0];
            r_my <= ay[MAG_W-1:0];
        end
        if (i_cmd.sq_x) begin
            r_sq <= r_mx * r_mx;
        end
        if (i_cmd.sq_y) begin
            r_sq2 <= r_my * r_my;
        end
        if (i_cmd.init_root) begin
            r_rad  <= {1'b0, SUM_W'(r_sq) + SUM_W'(r_sq2), 32'd0};
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end
        if (i_cmd.step_root) begin
            r_rad  <= r_rad << 2;
            r_rem  <= root_ge ? rem_sh - trial : rem_sh;
            r_root <= {r_root[ROOT_W-2:0], root_ge};
            r_cnt  <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.init_div) begin
            r_dvd  <= r_root;
            r_drem <= '0;
            r_cnt  <= '0;
        end
        if (i_cmd.step_div) begin
            r_drem <= div_ge ? drem_sh - {1'b0, dvs} : drem_sh;
            r_dvd  <= {r_dvd[ROOT_W-2:0], div_ge};
            r_cnt  <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.cap) begin
            r_result <= r_mode ? pct : '0;
            r_x      <= CX_W'(64'd1 << 36);
            r_y      <= {3'b000, tan_c, 20'd0};
            r_z      <= '0;
            r_cnt    <= '0;
        end
        if (i_cmd.step_cord) begin
            if (r_y > 0) begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + ang;
            end else begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - ang;
            end
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.fin) begin
            r_result <= {{(SAMPLE_W-ANG_W+8){1'b0}}, z_rnd[ANG_W-1:8]};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_val  <= i_cmd.out_nod ? r_nodata : r_result;
            r_out_nod  <= i_cmd.out_nod;
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_valid       = r_ov;
    assign o_slope_value = r_out_val;
    assign o_is_nodata   = r_out_nod;
    assign o_last_of_run = r_out_last;

    // status to the controller
    always_comb begin
        o_st.act       = r_act;
        o_st.col0      = r_col0;
        o_st.cmp       = r_cmp;
        o_st.sec       = r_sec;
        o_st.win_nod   = win_nod;
        o_st.mode      = r_mode;
        o_st.tan_zero  = (tan_c == '0);
        o_st.root_done = (r_cnt == CNT_W'(ROOT_STEPS - 1));
        o_st.div_done  = (r_cnt == CNT_W'(DIV_STEPS - 1));
        o_st.cord_done = (r_cnt == CNT_W'(CORDIC_STEPS - 1));
        o_st.out_free  = !r_ov || i_ready;
    end
endmodule

/* rtl/dsh_ctrl.sv */
// controller: sequences one item through read, compute and result delivery
module dsh_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  dsh_pkg::t_status i_st,
    output logic             o_ready,
    output dsh_pkg::t_cmd    o_cmd
);
    import dsh_pkg::*;

    t_state r_state, n_state;
    logic   r_first_nod, n_first_nod;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first_nod <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_first_nod <= n_first_nod;
        end
    end

    // next state
    always_comb begin
        n_state     = r_state;
        n_first_nod = r_first_nod;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_READ;
            end
            S_READ: n_state = S_DECIDE;
            S_DECIDE: begin
                n_first_nod = i_st.col0 || i_st.win_nod;
                if (!i_st.act) begin
                    n_state = S_IDLE;
                end else if (i_st.col0) begin
                    n_state = S_EMIT1;
                end else if (i_st.cmp) begin
                    n_state = i_st.win_nod ? S_EMIT1 : S_SQX;
                end else begin
                    n_state = i_st.sec ? S_EMIT2 : S_IDLE;
                end
            end
            S_SQX:  n_state = S_SQY;
            S_SQY:  n_state = S_SUM;
            S_SUM:  n_state = S_ROOT;
            S_ROOT: begin
                if (i_st.root_done) n_state = S_DIVI;
            end
            S_DIVI: n_state = S_DIV;
            S_DIV: begin
                if (i_st.div_done) n_state = S_CAP;
            end
            S_CAP: begin
                n_state = (i_st.mode || i_st.tan_zero) ? S_EMIT1 : S_CORD;
            end
            S_CORD: begin
                if (i_st.cord_done) n_state = S_FIN;
            end
            S_FIN: n_state = S_EMIT1;
            S_EMIT1: begin
                if (i_st.out_free) n_state = i_st.sec ? S_EMIT2 : S_IDLE;
            end
            S_EMIT2: begin
                if (i_st.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
            end
            S_READ:   o_cmd.ram_wr     = 1'b1;
            S_DECIDE: o_cmd.latch_grad = 1'b1;
            S_SQX:    o_cmd.sq_x       = 1'b1;
            S_SQY:    o_cmd.sq_y       = 1'b1;
            S_SUM:    o_cmd.init_root  = 1'b1;
            S_ROOT:   o_cmd.step_root  = 1'b1;
            S_DIVI:   o_cmd.init_div   = 1'b1;
            S_DIV:    o_cmd.step_div   = 1'b1;
            S_CAP:    o_cmd.cap        = 1'b1;
            S_CORD:   o_cmd.step_cord  = 1'b1;
            S_FIN:    o_cmd.fin        = 1'b1;
            S_EMIT1: begin
                o_cmd.load_out = i_st.out_free;
                o_cmd.out_nod  = r_first_nod;
                o_cmd.out_last = !i_st.sec;
            end
            S_EMIT2: begin
                o_cmd.load_out = i_st.out_free;
                o_cmd.out_nod  = 1'b1;
                o_cmd.out_last = 1'b1;
            end
            default: ;
        endcase
    end

`ifndef SYNTH
    // accepted item goes straight to the buffer read
    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> r_state == S_READ)
        else $error("accepted item did not go to read");

    // a first result that is not last is always followed by the border result
    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_out && !o_cmd.out_last) |=> r_state == S_EMIT2)
        else $error("missing second result of the item");

    // second result is always nodata and last
    a_second_nod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT2 && o_cmd.load_out) |-> (o_cmd.out_nod && o_cmd.out_last))
        else $error("second result not flagged as border");

    // root stays in its loop until the final digit
    a_root_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT && !i_st.root_done) |=> r_state == S_ROOT)
        else $error("square root left early");
`endif
endmodule

/* tb/dem_slope_3x3_horn_checker.sv */
// result checker for the horn 3x3 slope block: slope prediction and comparison
module dem_slope_3x3_horn_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [dsh_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dsh_pkg::SAMPLE_W-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic signed [31:0]            i_elevation,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic signed [31:0]            i_slope_value,
    input  logic                          i_is_nodata,
    input  logic                          i_last_of_run,
    output int                            o_fail_count,
    output int                            o_pending
);
    import dsh_pkg::*;

    typedef struct packed {
        logic [31:0] slope;
        logic        nod;
        logic        last;
    } t_slope_res;

    localparam logic [63:0] TAN_LIMIT = 64'd1 << 40;

    // arctangent of 2^-i in Q.16 degrees
    localparam longint ATAN_DEG [23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
    };

    t_slope_res slope_queue[$];

    // predictor copy of block state and registers
    logic signed [31:0] upper_row [MAX_COLUMNS];
    logic signed [31:0] middle_row [MAX_COLUMNS];
    longint             win [9];
    int unsigned        col_pos;
    int unsigned        rows_done;
    logic [12:0]        row_len_reg;
    logic [31:0]        nodata_reg;
    logic [23:0]        cell_reg;
    logic               mode_reg;

    assign o_pending = slope_queue.size();

    // tangent of the slope in Q.16 from the Horn sums
    function automatic logic [63:0] tan_q16(longint gx, longint gy, logic [23:0] cs);
        logic [127:0] ax, ay, g, n, cand, root;
        logic [63:0]  dv, t;
        ax = (gx < 0) ? 128'(-gx) : 128'(gx);
        ay = (gy < 0) ? 128'(-gy) : 128'(gy);
        g = ax * ax + ay * ay;
        if (g >= (128'd1 << 96)) begin
            return TAN_LIMIT;
        end
        n = g << 32;
        root = 0;
        for (int b = 63; b >= 0; b--) begin
            cand = root | (128'd1 << b);
            if (cand * cand <= n) begin
                root = cand;
            end
        end
        dv = 64'd8 * ((cs == 0) ? 64'd1 : 64'(cs));
        t = 64'(root / 128'(dv));
        return (t > TAN_LIMIT) ? TAN_LIMIT : t;
    endfunction

    // vectoring cordic to Q.8 degrees
    function automatic logic [31:0] tan_to_deg(logic [63:0] t);
        longint x, y, z, dx, dy;
        x = longint'(1) << 36;
        y = longint'(t << 20);
        z = 0;
        if (t == 0) begin
            return 0;
        end
        for (int i = 0; i < 23; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += ATAN_DEG[i];
            end else begin
                x -= dx; y += dy; z -= ATAN_DEG[i];
            end
        end
        if (z < 0) z = 0;
        if (z > 5898240) z = 5898240;
        return 32'((z + 128) >>> 8);
    endfunction

    // slope of the cell at the window center
    function automatic t_slope_res cell_slope();
        t_slope_res r;
        longint nd, gx, gy;
        logic [63:0] t, p;
        nd = longint'($signed(nodata_reg));
        r.last = 0;
        r.nod = 0;
        for (int k = 0; k < 9; k++) begin
            if (win[k] == nd) r.nod = 1;
        end
        if (r.nod) begin
            r.slope = nodata_reg;
            return r;
        end
        gx = (win[2] - win[0]) + 2 * (win[5] - win[3]) + (win[8] - win[6]);
        gy = (win[0] - win[6]) + 2 * (win[1] - win[7]) + (win[2] - win[8]);
        t = tan_q16(gx, gy, cell_reg);
        if (mode_reg) begin
            p = (t * 100 + 128) >> 8;
            r.slope = (p > 64'h7fff_ffff) ? 32'h7fff_ffff : p[31:0];
        end else begin
            r.slope = tan_to_deg(t);
        end
        return r;
    endfunction

    // advance the predicted state by one sample and queue its results
    task automatic predict_sample(logic signed [31:0] e);
        int unsigned len, c;
        logic signed [31:0] top, mid;
        bit last;
        t_slope_res r, outs[$];
        len = row_len_reg;
        c = col_pos;
        if (len < 3) len = 3;
        if (len > MAX_COLUMNS) len = MAX_COLUMNS;
        if (c >= MAX_COLUMNS) c = MAX_COLUMNS - 1;
        last = (c >= len - 1);
        top = upper_row[c];
        mid = middle_row[c];
        upper_row[c] = mid;
        middle_row[c] = e;
        win[0] = win[1]; win[1] = win[2]; win[2] = top;
        win[3] = win[4]; win[4] = win[5]; win[5] = mid;
        win[6] = win[7]; win[7] = win[8]; win[8] = e;
        if (rows_done >= 2) begin
            if (c == 0) begin
                r = '{slope: nodata_reg, nod: 1, last: 0};
                outs.push_back(r);
            end else if (c >= 2) begin
                outs.push_back(cell_slope());
            end
            if (last && c >= 1) begin
                r = '{slope: nodata_reg, nod: 1, last: 0};
                outs.push_back(r);
            end
            if (outs.size() > 0) outs[outs.size()-1].last = 1;
            foreach (outs[i]) slope_queue.push_back(outs[i]);
        end
        if (last) begin
            col_pos = 0;
            if (rows_done < 2) rows_done++;
        end else begin
            col_pos = c + 1;
        end
    endtask

    initial begin
        o_fail_count = 0;
        foreach (upper_row[i]) begin
            upper_row[i] = 0;
            middle_row[i] = 0;
        end
    end

    // watch the channels at each edge
    always @(posedge i_clk) begin
        t_slope_res want;
        if (!i_rst_n) begin
            slope_queue.delete();
            foreach (win[k]) win[k] = 0;
            col_pos = 0;
            rows_done = 0;
            row_len_reg = RST_ROW_LENGTH;
            nodata_reg = RST_NODATA_VALUE;
            cell_reg = RST_CELL_SIZE;
            mode_reg = 0;
        end else begin
            // compare results against the oldest expectation
            if (i_out_valid && i_out_ready) begin
                if (slope_queue.size() == 0) begin
                    $display("%0t: unexpected result slope %0d nod %0b last %0b",
                             $time, i_slope_value, i_is_nodata, i_last_of_run);
                    o_fail_count++;
                end else begin
                    want = slope_queue.pop_front();
                    if (want.slope !== i_slope_value) begin
                        $display("%0t: slope_value expected %0d actual %0d", $time,
                                 $signed(want.slope), i_slope_value);
                        o_fail_count++;
                    end
                    if (want.nod !== i_is_nodata) begin
                        $display("%0t: is_nodata expected %0b actual %0b", $time,
                                 want.nod, i_is_nodata);
                        o_fail_count++;
                    end
                    if (want.last !== i_last_of_run) begin
                        $display("%0t: last_of_run expected %0b actual %0b", $time,
                                 want.last, i_last_of_run);
                        o_fail_count++;
                    end
                end
            end
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ROW_LENGTH:   row_len_reg = i_cfg_data[12:0];
                    CFG_NODATA_VALUE: nodata_reg = i_cfg_data;
                    CFG_CELL_SIZE:    cell_reg = i_cfg_data[23:0];
                    CFG_SLOPE_MODE:   mode_reg = i_cfg_data[0];
                    default: ;
                endcase
            end
            // accepted samples
            if (i_in_valid && i_in_ready) begin
                predict_sample(i_elevation);
            end
        end
    end
endmodule

/* tb/dem_slope_3x3_horn_core_tb.sv */
// testbench top for the horn 3x3 slope block: stimulus, watchdog and verdict
module dem_slope_3x3_horn_core_tb;
    import dsh_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE      = 300;
    localparam int FILL_LEN    = 16;

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_cfg_valid = 0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_ROW_LENGTH;
    logic [SAMPLE_W-1:0]  i_cfg_data = 0;
    logic                 i_valid = 0;
    logic                 o_ready;
    logic signed [31:0]   i_elevation = 0;
    logic                 o_valid;
    logic                 i_ready = 0;
    logic signed [31:0]   o_slope_value;
    logic                 o_is_nodata;
    logic                 o_last_of_run;

    int fail_count, pending;
    int send_gap_pct = 20;
    int recv_gap_pct = 74;
    int quiet_cycles = 0;
    logic signed [31:0] cur_nodata = RST_NODATA_VALUE;
    logic signed [31:0] terrain_base = 0;

    dem_slope_3x3_horn_core dut (.*);

    dem_slope_3x3_horn_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_valid), .i_in_ready(o_ready), .i_elevation(i_elevation),
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_slope_value(o_slope_value), .i_is_nodata(o_is_nodata),
        .i_last_of_run(o_last_of_run),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_gap_pct);
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one elevation item, with a random lead-in gap
    task automatic send_sample(logic signed [31:0] e);
        if ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_gap_pct) @(posedge i_clk);
        end
        i_valid <= 1;
        i_elevation <= e;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // let every expected result drain and the block go quiet
    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // one register write, valid left high for a following write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic set_config(logic [12:0] len, logic [31:0] nd, logic [23:0] cs, logic md);
        drain();
        write_reg(CFG_ROW_LENGTH, 32'(len));
        write_reg(CFG_NODATA_VALUE, nd);
        write_reg(CFG_CELL_SIZE, 32'(cs));
        write_reg(CFG_SLOPE_MODE, 32'(md));
        i_cfg_valid <= 0;
        cur_nodata = nd;
    endtask

    // mostly smooth terrain, some noise, nodata and extremes
    function automatic logic signed [31:0] terrain_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            terrain_base = terrain_base + $signed($urandom_range(8000)) - 4000;
            return terrain_base;
        end else if (pick < 80) begin
            return $urandom;
        end else if (pick < 86) begin
            return cur_nodata;
        end else if (pick < 90) begin
            return ($urandom_range(1)) ? 32'sh7fff_ffff : 32'sh8000_0000;
        end else begin
            return $signed($urandom_range(2000000)) - 1000000;
        end
    endfunction

    function automatic logic [23:0] pick_cell();
        case ($urandom_range(5))
            0: return 24'd1;
            1: return 24'hff_ffff;
            2: return 24'd0;
            3: return 24'($urandom);
            default: return 24'(256 * $urandom_range(1, 40));
        endcase
    endfunction

    function automatic logic [31:0] pick_nodata();
        case ($urandom_range(4))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom;
            default: return RST_NODATA_VALUE;
        endcase
    endfunction

    initial begin
        int done_items;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // rows wider than the later random rows fill the buffer columns in use,
        // other registers keep their reset values
        write_reg(CFG_ROW_LENGTH, 32'(FILL_LEN));
        i_cfg_valid <= 0;
        for (int i = 0; i < 3 * FILL_LEN + 8; i++) begin
            send_sample((i == 2 * FILL_LEN + 4) ? RST_NODATA_VALUE
                                                : terrain_sample());
        end

        // steep extremes, saturating percent and capped tangent
        set_config(13'd3, 32'h8000_0000, 24'd1, 1'b1);
        send_sample(32'sh7fff_ffff); send_sample(32'sh8000_0001);
        send_sample(32'sh7fff_ffff); send_sample(32'sh8000_0001);
        send_sample(32'sh7fff_ffff); send_sample(32'sh8000_0001);
        send_sample(32'sh8000_0000); send_sample(32'sh7fff_ffff);
        send_sample(0);

        // flat ground gives zero slope, max nodata code, widest cell
        set_config(13'd4, 32'h7fff_ffff, 24'hff_ffff, 1'b0);
        repeat (6) send_sample(0);
        send_sample(32'sh7fff_ffff);
        send_sample(-1);

        // row length below the minimum and zero cell size
        set_config(13'd0, 32'h0000_0000, 24'd0, 1'b0);
        send_sample(100); send_sample(5000); send_sample(0); send_sample(-300);

        // row length above the maximum, then shrink mid-row
        set_config(13'h1fff, RST_NODATA_VALUE, RST_CELL_SIZE, 1'b1);
        repeat (3) send_sample(terrain_sample());

        // random phases with changing settings and idling patterns
        done_items = 0;
        while (done_items < 1500) begin
            if (done_items >= 1000) begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end else if (done_items >= 500) begin
                send_gap_pct = 74;
                recv_gap_pct = 20;
            end
            set_config(13'($urandom_range(3, 10)), pick_nodata(), pick_cell(),
                       1'($urandom_range(1)));
            terrain_base = $urandom_range(200000);
            for (int k = $urandom_range(20, 60); k > 0; k--) begin
                send_sample(terrain_sample());
                done_items++;
                // hold off once until the block has delivered everything
                if (done_items == 250) drain();
            end
        end

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

/* dem_slope_3x3_horn_core.f */
rtl/dsh_pkg.sv
rtl/dsh_ram.sv
rtl/dsh_dp.sv
rtl/dsh_ctrl.sv
rtl/dem_slope_3x3_horn_core.sv
tb/dem_slope_3x3_horn_checker.sv
tb/dem_slope_3x3_horn_core_tb.sv
